@@ hdl/ajb_pkg.sv @@
// Shared sizes and types for the audio jitter buffer.
package ajb_pkg;

  localparam int SLOTS      = 64;
  localparam int FRAME_CAP  = 512;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int LEN_W   = $clog2(FRAME_CAP + 1);
  localparam int POS_W   = (LEN_W > 10) ? LEN_W : 10;
  localparam int SEQ_W   = 32;
  localparam int META_W  = SEQ_W + LEN_W;
  localparam int SDEPTH  = SLOTS * FRAME_CAP;
  localparam int SAW     = $clog2(SDEPTH);
  localparam int DEPTH_W = 7;

  // Item kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_TARGET  = 2'd0;
  localparam logic [1:0] REG_RESYNC  = 2'd1;
  localparam logic [1:0] REG_MAXCONC = 2'd2;
  localparam logic [1:0] REG_DEFLEN  = 2'd3;

  // Slot metadata word: length over sequence number
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] seq;
  } meta_t;

endpackage

@@ hdl/ajb_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ajb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/audio_jitter_buffer.sv @@
// Audio jitter buffer top level: packet store, scan sequencer and playback.
//
// Items are taken one at a time; in_ready is high only while the block is
// idle. A push sample that continues a packet is stored and its result handed
// on. The first sample of a packet runs one scan of the slot table (one
// metadata RAM read per cycle); while playing, the distance check comes first
// and a late packet skips the scan. A pop runs one scan to find the packet at
// the play position, unless playback has not started and the store is below
// target; starting playback adds one scan, each packet finished on the way
// adds one, and shedding backlog adds one per shed packet plus one more such
// round. A result may wait for out_ready. All slot searches share the single
// scan unit over the metadata RAM. No clearing pass follows reset.
module audio_jitter_buffer import ajb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [31:0]         seq,
  input  logic signed [15:0]  sample,
  input  logic                frame_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  sample_out,
  output logic                sample_valid,
  output logic [DEPTH_W-1:0]  depth,
  output logic                packet_dropped,
  output logic                resynced,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [15:0]         wr_data
);

  localparam int CMP_W = 10;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH_D, S_PUSH_C, S_SCAN, S_AFTER, S_PUSH_W,
    S_LOOP, S_SHED_CHK, S_POP_RD, S_POP_CAP, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    R_PUSH, R_START, R_SHED, R_SHEDMIN, R_FIND
  } ret_t;

  state_t state;
  ret_t   scan_ret;

  // Configuration
  logic [5:0]  target_depth;
  logic [15:0] resync_distance;
  logic [7:0]  max_conceal;
  logic [9:0]  default_conceal_len;

  // Buffer state
  logic [SLOTS-1:0]  used;
  logic [CNT_W-1:0]  count;
  logic [SEQ_W-1:0]  play_seq;
  logic              playing;
  logic [POS_W-1:0]  packet_len;
  logic [POS_W-1:0]  play_pos;
  logic [7:0]        conceal_run;
  logic [SLOT_W-1:0] write_slot;
  logic [LEN_W-1:0]  write_pos;
  logic              in_packet;
  logic              discard;

  // Captured item
  logic [SEQ_W-1:0]  it_seq;
  logic [15:0]       it_sample;
  logic              it_last;

  // Result under construction
  logic [15:0] r_sample;
  logic        r_valid;
  logic        r_drop;
  logic        r_resync;

  logic signed [SEQ_W:0] seq_gap;

  // Scan unit
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] chk_idx;
  logic              chk_vld;
  logic [SEQ_W-1:0]  scan_key;
  logic              hit_f, min_f, free_f;
  logic [SLOT_W-1:0] hit_idx, min_idx, free_idx;
  logic [LEN_W-1:0]  hit_len, min_len;
  logic [SEQ_W-1:0]  min_seq;

  // RAM ports
  meta_t             meta_wdata, meta_rdata;
  logic              meta_we;
  logic              smp_we;
  logic [SAW-1:0]    smp_waddr, smp_raddr;
  logic [15:0]       smp_rdata;

  // Derived values
  logic [5:0]        eff_t;
  logic [CMP_W-1:0]  cnt_x, t_x, t2_x;
  logic              wr_ok;
  logic [LEN_W-1:0]  wp_new;
  logic [POS_W-1:0]  clen;
  logic [POS_W:0]    pp1;
  logic signed [SEQ_W:0] rd_s;

  assign eff_t  = (target_depth == 6'd0) ? 6'd3 : target_depth;
  assign cnt_x  = CMP_W'(count);
  assign t_x    = CMP_W'(eff_t);
  assign t2_x   = CMP_W'({eff_t, 1'b0});
  assign wr_ok  = !discard && (write_pos < LEN_W'(FRAME_CAP));
  assign wp_new = wr_ok ? write_pos + LEN_W'(1) : write_pos;
  assign clen   = (packet_len == '0) ? POS_W'(default_conceal_len) : packet_len;
  assign pp1    = {1'b0, play_pos} + (POS_W+1)'(1);
  assign rd_s   = (SEQ_W+1)'(resync_distance);

  assign in_ready = (state == S_IDLE);

  // RAM control
  assign meta_we    = (state == S_PUSH_W) && it_last && !discard &&
                      !used[write_slot] && (count < CNT_W'(SLOTS));
  assign meta_wdata = '{len: wp_new, seq: it_seq};
  assign smp_we     = (state == S_PUSH_W) && wr_ok;
  assign smp_waddr  = SAW'(write_slot) * SAW'(FRAME_CAP) + SAW'(write_pos);
  assign smp_raddr  = SAW'(hit_idx) * SAW'(FRAME_CAP) + SAW'(play_pos);

  ajb_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (write_slot),
    .wdata (meta_wdata),
    .raddr (scan_addr),
    .rdata (meta_rdata)
  );

  ajb_ram #(.WIDTH(16), .DEPTH(SDEPTH)) u_samples (
    .clk   (clk),
    .we    (smp_we),
    .waddr (smp_waddr),
    .wdata (it_sample),
    .raddr (smp_raddr),
    .rdata (smp_rdata)
  );

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      scan_ret            <= R_PUSH;
      target_depth        <= 6'd3;
      resync_distance     <= 16'd200;
      max_conceal         <= 8'd50;
      default_conceal_len <= 10'd480;
      used                <= '0;
      count               <= '0;
      play_seq            <= '0;
      playing             <= 1'b0;
      packet_len          <= '0;
      play_pos            <= '0;
      conceal_run         <= '0;
      write_slot          <= '0;
      write_pos           <= '0;
      in_packet           <= 1'b0;
      discard             <= 1'b0;
      out_valid           <= 1'b0;
      chk_vld             <= 1'b0;
    end else begin
      // Configuration writes
      if (wr_en) begin
        unique case (wr_index)
          REG_TARGET:  target_depth        <= wr_data[5:0];
          REG_RESYNC:  resync_distance     <= wr_data;
          REG_MAXCONC: max_conceal         <= wr_data[7:0];
          REG_DEFLEN:  default_conceal_len <= wr_data[9:0];
          default: ;
        endcase
      end

      // Result beat taken; S_DONE handles its own handoff
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            it_seq    <= seq;
            it_sample <= sample;
            it_last   <= frame_last;
            r_sample  <= '0;
            r_valid   <= 1'b0;
            r_drop    <= 1'b0;
            r_resync  <= 1'b0;
            scan_key  <= seq;
            unique case (kind)
              KIND_PUSH: begin
                if (!in_packet) begin
                  in_packet <= 1'b1;
                  discard   <= 1'b0;
                  write_pos <= '0;
                  if (playing) begin
                    state <= S_PUSH_D;
                  end else begin
                    state    <= S_SCAN;
                    scan_ret <= R_PUSH;
                    scan_addr <= '0;
                    chk_vld  <= 1'b0;
                    hit_f <= 1'b0; min_f <= 1'b0; free_f <= 1'b0;
                  end
                end else begin
                  state <= S_PUSH_W;
                end
              end
              KIND_POP: begin
                if (!playing) begin
                  if (cnt_x < t_x) begin
                    state <= S_DONE;
                  end else begin
                    state    <= S_SCAN;
                    scan_ret <= R_START;
                    scan_addr <= '0;
                    chk_vld  <= 1'b0;
                    hit_f <= 1'b0; min_f <= 1'b0; free_f <= 1'b0;
                  end
                end else begin
                  state <= S_LOOP;
                end
              end
              KIND_RESET: begin
                used        <= '0;
                count       <= '0;
                play_seq    <= '0;
                playing     <= 1'b0;
                packet_len  <= '0;
                play_pos    <= '0;
                conceal_run <= '0;
                in_packet   <= 1'b0;
                discard     <= 1'b0;
                write_pos   <= '0;
                r_resync    <= 1'b1;
                state       <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // Distance from play position
        S_PUSH_D: begin
          seq_gap <= $signed({1'b0, it_seq}) - $signed({1'b0, play_seq});
          state   <= S_PUSH_C;
        end

        S_PUSH_C: begin
          if (seq_gap > rd_s || seq_gap < -rd_s) begin
            used        <= '0;
            count       <= '0;
            play_seq    <= '0;
            playing     <= 1'b0;
            packet_len  <= '0;
            play_pos    <= '0;
            conceal_run <= '0;
            r_resync    <= 1'b1;
            state       <= S_SCAN;
            scan_ret    <= R_PUSH;
            scan_addr   <= '0;
            chk_vld     <= 1'b0;
            hit_f <= 1'b0; min_f <= 1'b0; free_f <= 1'b0;
          end else if (seq_gap < 0) begin
            discard <= 1'b1;
            state   <= S_PUSH_W;
          end else begin
            state     <= S_SCAN;
            scan_ret  <= R_PUSH;
            scan_addr <= '0;
            chk_vld   <= 1'b0;
            hit_f <= 1'b0; min_f <= 1'b0; free_f <= 1'b0;
          end
        end

        // One pass over the slot table: match, minimum and first free
        S_SCAN: begin
          chk_vld <= 1'b1;
          chk_idx <= scan_addr;
          if (scan_addr != SLOT_W'(SLOTS - 1)) begin
            scan_addr <= scan_addr + SLOT_W'(1);
          end
          if (chk_vld) begin
            if (used[chk_idx] && meta_rdata.seq == scan_key && !hit_f) begin
              hit_f   <= 1'b1;
              hit_idx <= chk_idx;
              hit_len <= meta_rdata.len;
            end
            if (used[chk_idx] && (!min_f || meta_rdata.seq < min_seq)) begin
              min_f   <= 1'b1;
              min_idx <= chk_idx;
              min_seq <= meta_rdata.seq;
              min_len <= meta_rdata.len;
            end
            if (!used[chk_idx] && !free_f) begin
              free_f   <= 1'b1;
              free_idx <= chk_idx;
            end
            if (chk_idx == SLOT_W'(SLOTS - 1)) begin
              chk_vld <= 1'b0;
              state   <= S_AFTER;
            end
          end
        end

        // Act on the scan outcome
        S_AFTER: begin
          unique case (scan_ret)
            R_PUSH: begin
              state <= S_PUSH_W;
              if (hit_f) begin
                discard <= 1'b1;
              end else if (count >= CNT_W'(SLOTS)) begin
                used[min_idx] <= 1'b0;
                count         <= count - CNT_W'(1);
                write_slot    <= min_idx;
              end else if (free_f) begin
                write_slot <= free_idx;
              end else begin
                discard <= 1'b1;
              end
            end
            R_START: begin
              playing     <= 1'b1;
              play_seq    <= min_f ? min_seq : '0;
              play_pos    <= '0;
              conceal_run <= '0;
              if (packet_len == '0 && min_f) begin
                packet_len <= POS_W'(min_len);
              end
              state <= S_LOOP;
            end
            R_SHED: begin
              if (min_f) begin
                used[min_idx] <= 1'b0;
                count         <= count - CNT_W'(1);
              end
              state <= S_SHED_CHK;
            end
            R_SHEDMIN: begin
              if (min_f) begin
                play_seq <= min_seq;
              end
              play_pos    <= '0;
              conceal_run <= '0;
              state       <= S_LOOP;
            end
            R_FIND: begin
              if (hit_f) begin
                if (play_pos < POS_W'(hit_len) && play_pos < POS_W'(FRAME_CAP)) begin
                  state <= S_POP_RD;
                end else begin
                  used[hit_idx] <= 1'b0;
                  count         <= count - CNT_W'(1);
                  play_seq      <= play_seq + SEQ_W'(1);
                  play_pos      <= '0;
                  conceal_run   <= '0;
                  state         <= S_LOOP;
                end
              end else begin
                // Missing packet: play silence
                r_sample <= '0;
                r_valid  <= 1'b1;
                state    <= S_DONE;
                if (pp1 >= (POS_W+1)'(clen)) begin
                  play_pos <= '0;
                  if (conceal_run >= max_conceal) begin
                    used        <= '0;
                    count       <= '0;
                    play_seq    <= '0;
                    playing     <= 1'b0;
                    packet_len  <= '0;
                    conceal_run <= '0;
                    r_resync    <= 1'b1;
                  end else begin
                    play_seq    <= play_seq + SEQ_W'(1);
                    conceal_run <= conceal_run + 8'd1;
                  end
                end else begin
                  play_pos <= pp1[POS_W-1:0];
                end
              end
            end
            default: state <= S_DONE;
          endcase
        end

        // Store the sample and close the packet on its last beat
        S_PUSH_W: begin
          if (!wr_ok) begin
            r_drop <= 1'b1;
          end
          write_pos <= wp_new;
          if (it_last) begin
            if (meta_we) begin
              used[write_slot] <= 1'b1;
              count            <= count + CNT_W'(1);
              if (packet_len == '0) begin
                packet_len <= POS_W'(wp_new);
              end
            end
            in_packet <= 1'b0;
            discard   <= 1'b0;
          end
          state <= S_DONE;
        end

        // Playback iteration: shed backlog or look up the play packet
        S_LOOP: begin
          scan_addr <= '0;
          chk_vld   <= 1'b0;
          hit_f <= 1'b0; min_f <= 1'b0; free_f <= 1'b0;
          if (play_pos == '0 && cnt_x > t2_x) begin
            state <= S_SHED_CHK;
          end else begin
            scan_key <= play_seq;
            scan_ret <= R_FIND;
            state    <= S_SCAN;
          end
        end

        S_SHED_CHK: begin
          scan_addr <= '0;
          chk_vld   <= 1'b0;
          hit_f <= 1'b0; min_f <= 1'b0; free_f <= 1'b0;
          scan_ret  <= (cnt_x > t_x) ? R_SHED : R_SHEDMIN;
          state     <= S_SCAN;
        end

        S_POP_RD: state <= S_POP_CAP;

        S_POP_CAP: begin
          r_sample <= smp_rdata;
          r_valid  <= 1'b1;
          play_pos <= play_pos + POS_W'(1);
          state    <= S_DONE;
        end

        // Hand the result to the output register
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            sample_out     <= r_sample;
            sample_valid   <= r_valid;
            depth          <= DEPTH_W'(count);
            packet_dropped <= r_drop;
            resynced       <= r_resync;
            state          <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/audio_jitter_buffer_tb.sv @@
// Testbench for the audio jitter buffer: packet pushes, playback pops and resets vs a predictor.
module audio_jitter_buffer_tb;
  import ajb_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam logic [1:0] KIND_IGNORED = 2'd3;

  // one result beat as the block reports it
  typedef struct {
    logic [15:0] smp;
    bit          sval;
    bit [6:0]    dep;
    bit          drop;
    bit          rsync;
  } play_beat_t;

  // Playout predictor: slot store, playback state and the expected beats
  class playout_predictor;
    logic [15:0]  pcm [SLOTS*FRAME_CAP];
    logic [31:0]  sq [SLOTS];
    int unsigned  ln [SLOTS];
    bit           used [SLOTS];
    int unsigned  count, plen, ppos, crun, wslot, wpos;
    logic [31:0]  pseq;
    bit           playing, in_pkt, discard;
    int unsigned  tgt, rdist, mconc, dlen;
    play_beat_t   expected_beats[$];
    bit           failed;

    function new();
      foreach (used[i]) used[i] = 0;
      count = 0; pseq = 0; playing = 0; plen = 0; ppos = 0; crun = 0;
      wslot = 0; wpos = 0; in_pkt = 0; discard = 0;
      tgt = 3; rdist = 200; mconc = 50; dlen = 480;
      failed = 0;
    endfunction

    function void clear_play();
      foreach (used[i]) used[i] = 0;
      count = 0; pseq = 0; playing = 0; plen = 0; ppos = 0; crun = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_TARGET:  tgt = val[5:0];
        REG_RESYNC:  rdist = val;
        REG_MAXCONC: mconc = val[7:0];
        REG_DEFLEN:  dlen = val[9:0];
      endcase
    endfunction

    function int find_slot(logic [31:0] s);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && sq[i] == s) return i;
      return -1;
    endfunction

    function int oldest_slot();
      int b;
      b = -1;
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && (b < 0 || sq[i] < sq[b])) b = i;
      return b;
    endfunction

    function void drop_slot(int i);
      if (i >= 0 && used[i]) begin
        used[i] = 0;
        if (count > 0) count--;
      end
    endfunction

    function void push_sample(logic [31:0] s, logic [15:0] smp, bit last, ref play_beat_t r);
      longint d;
      int f;
      if (!in_pkt) begin
        in_pkt = 1; discard = 0; wpos = 0;
        if (playing) begin
          d = longint'(s) - longint'(pseq);
          if (d < -longint'(rdist) || d > longint'(rdist)) begin
            clear_play();
            r.rsync = 1;
          end else if (d < 0) discard = 1;
        end
        if (!discard && find_slot(s) >= 0) discard = 1;
        if (!discard) begin
          f = -1;
          if (count >= SLOTS) drop_slot(oldest_slot());
          for (int i = 0; i < SLOTS && f < 0; i++)
            if (!used[i]) f = i;
          if (f < 0) discard = 1;
          else wslot = f;
        end
      end
      if (discard || wpos >= FRAME_CAP) r.drop = 1;
      else begin
        pcm[wslot*FRAME_CAP + wpos] = smp;
        wpos++;
      end
      if (last) begin
        if (!discard && !used[wslot] && count < SLOTS) begin
          sq[wslot] = s; ln[wslot] = wpos; used[wslot] = 1; count++;
          if (plen == 0) plen = wpos;
        end
        in_pkt = 0; discard = 0;
      end
    endfunction

    function void pop_sample(ref play_beat_t r);
      int unsigned t, clen;
      int k, m;
      t = (tgt == 0) ? 3 : tgt;
      if (!playing) begin
        if (count < t) return;
        k = oldest_slot();
        playing = 1;
        pseq = (k >= 0) ? sq[k] : 0;
        ppos = 0; crun = 0;
        if (plen == 0 && k >= 0) plen = ln[k];
      end
      for (int it = 0; it < SLOTS + 2; it++) begin
        // shed backlog down to target at a packet boundary
        if (ppos == 0 && count > 2*t) begin
          while (count > t) drop_slot(oldest_slot());
          m = oldest_slot();
          if (m >= 0) pseq = sq[m];
          ppos = 0; crun = 0;
        end
        k = find_slot(pseq);
        if (k >= 0) begin
          if (ppos < ln[k] && ppos < FRAME_CAP) begin
            r.smp = pcm[k*FRAME_CAP + ppos];
            r.sval = 1;
            ppos++;
            return;
          end
          drop_slot(k);
          pseq++; ppos = 0; crun = 0;
        end else begin
          // missing packet: play silence
          clen = (plen == 0) ? dlen : plen;
          if (clen == 0) clen = 1;
          r.smp = 0; r.sval = 1;
          ppos++;
          if (ppos >= clen) begin
            pseq++; ppos = 0;
            if (crun >= mconc) begin
              clear_play();
              r.rsync = 1;
            end else crun++;
          end
          return;
        end
      end
    endfunction

    // accepted input beat: work out its result
    function void note_input(logic [1:0] k, logic [31:0] s, logic [15:0] smp, bit last);
      play_beat_t r;
      r = '{smp: 0, sval: 0, dep: 0, drop: 0, rsync: 0};
      if (k == KIND_PUSH) push_sample(s, smp, last, r);
      else if (k == KIND_POP) pop_sample(r);
      else if (k == KIND_RESET) begin
        clear_play();
        in_pkt = 0; discard = 0; wpos = 0;
        r.rsync = 1;
      end
      r.dep = count;
      expected_beats.push_back(r);
    endfunction

    // accepted result beat: compare with the oldest expectation
    function void check_result(play_beat_t a);
      play_beat_t e;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat smp=%0h depth=%0d", $time, a.smp, a.dep);
        failed = 1;
        return;
      end
      e = expected_beats.pop_front();
      if (a.smp !== e.smp) begin
        $display("%0t: sample_out exp %0h act %0h", $time, e.smp, a.smp); failed = 1;
      end
      if (a.sval !== e.sval) begin
        $display("%0t: sample_valid exp %0d act %0d", $time, e.sval, a.sval); failed = 1;
      end
      if (a.dep !== e.dep) begin
        $display("%0t: depth exp %0d act %0d", $time, e.dep, a.dep); failed = 1;
      end
      if (a.drop !== e.drop) begin
        $display("%0t: packet_dropped exp %0d act %0d", $time, e.drop, a.drop); failed = 1;
      end
      if (a.rsync !== e.rsync) begin
        $display("%0t: resynced exp %0d act %0d", $time, e.rsync, a.rsync); failed = 1;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] kind;
  logic [31:0] seq;
  logic signed [15:0] sample;
  logic frame_last;
  logic out_valid, out_ready;
  logic signed [15:0] sample_out;
  logic sample_valid;
  logic [DEPTH_W-1:0] depth;
  logic packet_dropped, resynced;
  logic wr_en;
  logic [1:0] wr_index;
  logic [15:0] wr_data;

  playout_predictor pred = new();
  int unsigned cycles;
  bit no_idle;
  logic [31:0] next_seq;

  audio_jitter_buffer u_top (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      pred.check_result('{smp: sample_out, sval: sample_valid, dep: depth,
                          drop: packet_dropped, rsync: resynced});
  end

  // receiver stalls
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (no_idle || $urandom_range(0, 9) < 7) out_ready = 1;
      else out_ready = 0;
      if (!no_idle && $urandom_range(0, 199) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(10, 80)) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one input beat and wait for its handshake
  task automatic send_beat(logic [1:0] k, logic [31:0] s, logic [15:0] smp, bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (g) @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1; kind = k; seq = s; sample = smp; frame_last = last;
    do @(posedge clk); while (!in_ready);
    pred.note_input(k, s, smp, last);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pred.expected_beats.size() != 0) @(posedge clk);
  endtask

  // registers are written only with the block idle
  task automatic write_regs(logic [15:0] t, logic [15:0] rd, logic [15:0] mc, logic [15:0] dl);
    logic [15:0] v[4];
    v = '{t, rd, mc, dl};
    drain();
    repeat (5000) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      wr_en = 1; wr_index = 2'(i); wr_data = v[i];
      pred.write_reg(2'(i), v[i]);
    end
    @(negedge clk);
    wr_en = 0;
  endtask

  task automatic send_packet(logic [31:0] s, int n);
    for (int i = 0; i < n; i++)
      send_beat(KIND_PUSH, s, $urandom, i == n - 1);
  endtask

  task automatic pop_burst(int n);
    repeat (n) send_beat(KIND_POP, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // one phase of mostly well-formed traffic with random content
  task automatic run_phase(int budget);
    int sent, r, n;
    logic [31:0] s;
    sent = 0;
    // burst of packets with no playback: can fill the store and force eviction
    n = $urandom_range(20, 70);
    for (int i = 0; i < n; i++) begin
      send_packet(next_seq, 1);
      next_seq++;
    end
    sent += n;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin s = next_seq; next_seq++; end
      else if (r < 80) begin s = next_seq + $urandom_range(1, 3); next_seq = s + 1; end
      else if (r < 88) s = next_seq - $urandom_range(1, 4);
      else if (r < 94) begin
        s = ($urandom_range(0, 1)) ? next_seq + $urandom_range(300, 70000)
                                   : next_seq - $urandom_range(300, 70000);
        next_seq = s + 1;
      end else if (r < 97) begin s = $urandom; next_seq = s + 1; end
      else if (r < 98) begin
        send_beat(KIND_RESET, $urandom, $urandom, $urandom_range(0, 1));
        sent++;
        continue;
      end else begin
        send_beat(KIND_IGNORED, $urandom, $urandom, $urandom_range(0, 1));
        sent++;
        continue;
      end
      n = ($urandom_range(0, 199) == 0) ? $urandom_range(505, 520) : $urandom_range(1, 6);
      send_packet(s, n);
      sent += n;
      n = $urandom_range(0, 12);
      pop_burst(n);
      sent += n;
    end
  endtask

  initial begin
    rst = 1; cycles = 0; no_idle = 0;
    in_valid = 0; kind = KIND_PUSH; seq = 0; sample = 0; frame_last = 0;
    wr_en = 0; wr_index = REG_TARGET; wr_data = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: idle-state items, extreme samples, duplicate, late, long packet
    send_beat(KIND_IGNORED, 32'hFFFF_FFFF, 16'h7FFF, 1);
    send_beat(KIND_POP, 0, 0, 0);
    send_beat(KIND_PUSH, 32'd10, 16'h8000, 0);
    send_beat(KIND_PUSH, 32'd10, 16'h7FFF, 1);
    send_beat(KIND_PUSH, 32'd10, 16'hFFFF, 1);
    send_beat(KIND_PUSH, 32'd12, 16'h0001, 1);
    send_beat(KIND_PUSH, 32'd11, 16'h0000, 1);
    pop_burst(4);
    send_beat(KIND_PUSH, 32'd9, 16'h1234, 1);
    send_beat(KIND_PUSH, 32'd5000, 16'h4321, 1);
    send_beat(KIND_RESET, 0, 0, 0);
    send_beat(KIND_PUSH, 32'hFFFF_FFFF, 16'h5555, 1);
    send_beat(KIND_PUSH, 32'h0, 16'hAAAA, 1);
    send_beat(KIND_PUSH, 32'h1, 16'hAAAA, 1);
    pop_burst(4);
    send_packet(32'd100, 515);
    next_seq = 32'd101;

    // hold off until everything has come back
    drain();

    no_idle = 1;
    run_phase(200);
    no_idle = 0;
    write_regs(1, 0, 0, 1);
    run_phase(200);
    write_regs(32, 16'hFFFF, 255, 512);
    run_phase(200);
    write_regs(0, 5, 3, 0);
    run_phase(200);
    write_regs(2, 100, 10, 64);
    next_seq = 32'hFFFF_FFF0;
    run_phase(200);
    write_regs(16'($urandom_range(1, 32)), 16'($urandom), 16'($urandom_range(0, 255)),
               16'($urandom_range(1, 512)));
    next_seq = $urandom;
    run_phase(200);
    write_regs(8, 1000, 1, 16);
    run_phase(200);

    // final drain
    @(negedge clk);
    in_valid = 0;
    while (pred.expected_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (!pred.failed && pred.expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
